[sv/ubd_pkg.sv]
// ----------------------------------------------------------------------------
// ubd_pkg
// Types and constants shared by the baud divisor calculator.
// ----------------------------------------------------------------------------
package ubd_pkg;

	localparam int CLK_W    = 28;              // peripheral clock register
	localparam int RATE_W   = 26;              // requested baud rate
	localparam int DIV_W    = 16;              // divisor result
	localparam int NUM_W    = 33;              // clock * 25
	localparam int DEN_W    = 28;              // rate * 4 or rate * 2
	localparam int MANT_W   = 12;              // mantissa bits kept in the divisor
	localparam int R100_W   = 7;               // remainder modulo 100
	localparam int NCELLS   = NUM_W + 1;       // one extra cell drains the /100 step
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [CLK_W-1:0] CLK_RESET     = 28'd8000000;
	localparam logic [NUM_W-1:0] CLK_X25_RESET = 33'd200000000;
	localparam logic [NUM_W-1:0] SCALE_25      = 33'd25;
	localparam logic [7:0]       DEC_BASE      = 8'd100;
	localparam logic [10:0]      ROUND_HALF    = 11'd50;
	// floor(x / 100) == (x * 1311) >> 17 for x below 1700
	localparam logic [10:0]      RECIP_100     = 11'd1311;
	localparam int               RECIP_SHIFT   = 17;
	localparam logic [4:0]       STEPS_16      = 5'd16;
	localparam logic [4:0]       STEPS_8       = 5'd8;

	// register index, taken from paddr[2]
	localparam logic REG_CLK = 1'b0;
	localparam logic REG_OVS = 1'b1;

	typedef struct packed {
		logic [DEN_W-1:0]  rem;    // running remainder of the main division
		logic [NUM_W-1:0]  num;    // dividend bits still to consume, MSB first
		logic [DEN_W-1:0]  den;
		logic [R100_W-1:0] r100;   // running remainder of quotient / 100
		logic              qbit;   // quotient bit from the previous cell
		logic [MANT_W-1:0] mant;   // low bits of quotient / 100
		logic              zero;   // rate was zero
	} cell_t;

endpackage

[sv/ubd_req_if.sv]
// ----------------------------------------------------------------------------
// ubd_req_if
// Request channel: one baud rate per item.
// ----------------------------------------------------------------------------
interface ubd_req_if;
	logic                       valid;
	logic                       ready;
	logic [ubd_pkg::RATE_W-1:0] baud_rate;

	modport source (output valid, output baud_rate, input ready);
	modport sink (input valid, input baud_rate, output ready);
endinterface

[sv/ubd_rsp_if.sv]
// ----------------------------------------------------------------------------
// ubd_rsp_if
// Response channel: divisor and zero rate flag per item.
// ----------------------------------------------------------------------------
interface ubd_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [ubd_pkg::DIV_W-1:0] divisor;
	logic                      zero_rate_error;

	modport source (output valid, output divisor, output zero_rate_error, input ready);
	modport sink (input valid, input divisor, input zero_rate_error, output ready);
endinterface

[sv/ubd_apb.sv]
// ----------------------------------------------------------------------------
// ubd_apb
// Configuration registers: peripheral clock and oversampling mode.
// ----------------------------------------------------------------------------
module ubd_apb (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ubd_pkg::APB_AW-1:0] paddr,
	input  logic [ubd_pkg::APB_DW-1:0] pwdata,
	output logic [ubd_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output logic [ubd_pkg::NUM_W-1:0]  clk_x25,
	output logic                       by_eight
);

	logic [ubd_pkg::CLK_W-1:0] clk_hz_q;
	logic [ubd_pkg::NUM_W-1:0] clk_x25_q;
	logic                      by_eight_q;
	logic                      wr_en;
	logic                      reg_idx;
	logic [ubd_pkg::NUM_W-1:0] wr_x25;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[2];
	// clock * 25 is formed once per write, off the item path
	assign wr_x25  = {{(ubd_pkg::NUM_W-ubd_pkg::CLK_W){1'b0}}, pwdata[ubd_pkg::CLK_W-1:0]}
		* ubd_pkg::SCALE_25;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q   <= ubd_pkg::CLK_RESET;
			clk_x25_q  <= ubd_pkg::CLK_X25_RESET;
			by_eight_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				ubd_pkg::REG_CLK: begin
					clk_hz_q  <= pwdata[ubd_pkg::CLK_W-1:0];
					clk_x25_q <= wr_x25;
				end
				ubd_pkg::REG_OVS: begin
					by_eight_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ubd_pkg::REG_CLK: prdata = {{(ubd_pkg::APB_DW-ubd_pkg::CLK_W){1'b0}}, clk_hz_q};
			ubd_pkg::REG_OVS: prdata = {{(ubd_pkg::APB_DW-1){1'b0}}, by_eight_q};
			default:          prdata = '0;
		endcase
	end

	assign clk_x25  = clk_x25_q;
	assign by_eight = by_eight_q;

endmodule

[sv/ubd_cell.sv]
// ----------------------------------------------------------------------------
// ubd_cell
// One cell of the divider row: one restoring step of clock*25 / den, and one
// step of the running division of the quotient bit stream by 100.
// ----------------------------------------------------------------------------
module ubd_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  ubd_pkg::cell_t in_data,
	output logic           in_ready,
	output logic           out_valid,
	output ubd_pkg::cell_t out_data,
	input  logic           out_ready
);

	logic                        valid_q;
	ubd_pkg::cell_t              data_q;
	ubd_pkg::cell_t              step;
	logic [ubd_pkg::DEN_W:0]     sh;
	logic [ubd_pkg::DEN_W:0]     diff;
	logic                        q;
	logic [ubd_pkg::R100_W:0]    sh2;
	logic [ubd_pkg::R100_W:0]    diff2;
	logic                        m;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		sh    = {in_data.rem, in_data.num[ubd_pkg::NUM_W-1]};
		diff  = sh - {1'b0, in_data.den};
		q     = (sh >= {1'b0, in_data.den});
		// quotient bits arrive MSB first; long division by 100 on them
		sh2   = {in_data.r100, in_data.qbit};
		diff2 = sh2 - ubd_pkg::DEC_BASE;
		m     = (sh2 >= ubd_pkg::DEC_BASE);

		step      = in_data;
		step.rem  = q ? diff[ubd_pkg::DEN_W-1:0] : sh[ubd_pkg::DEN_W-1:0];
		step.num  = {in_data.num[ubd_pkg::NUM_W-2:0], 1'b0};
		step.qbit = q;
		step.r100 = m ? diff2[ubd_pkg::R100_W-1:0] : sh2[ubd_pkg::R100_W-1:0];
		step.mant = {in_data.mant[ubd_pkg::MANT_W-2:0], m};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= step;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

`ifndef SYNTHESIS
	a_r100_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ({1'b0, data_q.r100} < ubd_pkg::DEC_BASE))
		else $error("remainder mod 100 out of range");
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !data_q.zero) |-> (data_q.rem < data_q.den))
		else $error("division remainder not below divisor");
`endif

endmodule

[sv/ubd_post.sv]
// ----------------------------------------------------------------------------
// ubd_post
// Output stage: rounds the remainder mod 100 to sixteenths or eighths,
// carries a full fraction into the mantissa and holds the result item.
// ----------------------------------------------------------------------------
module ubd_post (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      by_eight,
	input  logic                      in_valid,
	input  ubd_pkg::cell_t            in_data,
	output logic                      in_ready,
	output logic                      out_valid,
	output logic [ubd_pkg::DIV_W-1:0] out_divisor,
	output logic                      out_zero,
	input  logic                      out_ready
);

	logic                         valid_q;
	logic [ubd_pkg::DIV_W-1:0]    divisor_q;
	logic                         zero_q;
	logic [10:0]                  scaled;
	logic [21:0]                  prod;
	logic [4:0]                   frac_raw;
	logic [4:0]                   steps;
	logic                         wrap;
	logic [ubd_pkg::MANT_W-1:0]   mant;
	logic [3:0]                   frac;
	logic [ubd_pkg::DIV_W-1:0]    divisor_d;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		scaled   = (by_eight ? {1'b0, in_data.r100, 3'b000} : {in_data.r100, 4'b0000})
			+ ubd_pkg::ROUND_HALF;
		prod     = {11'd0, scaled} * {11'd0, ubd_pkg::RECIP_100};
		frac_raw = prod[ubd_pkg::RECIP_SHIFT+4:ubd_pkg::RECIP_SHIFT];
		steps    = by_eight ? ubd_pkg::STEPS_8 : ubd_pkg::STEPS_16;
		wrap     = (frac_raw >= steps);
		mant     = wrap ? in_data.mant + 1'b1 : in_data.mant;
		frac     = wrap ? 4'd0 : frac_raw[3:0];
		divisor_d = in_data.zero ? '0 : {mant, frac};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			divisor_q <= divisor_d;
			zero_q    <= in_data.zero;
		end
	end

	assign out_valid   = valid_q;
	assign out_divisor = divisor_q;
	assign out_zero    = zero_q;

endmodule

[sv/usart_baud_divisor_calc.sv]
// Pipeline: an accepted request is loaded into the first of 34 divider cells,
//   passes through the cells in order, then through the rounding register.
// Throughput: one item per cycle; the row of cells is fully pipelined and each
//   cell stalls only when the cell after it is full.
// Reset: clock register to 8 MHz, 16x oversampling, every stage empty.
// ----------------------------------------------------------------------------
// usart_baud_divisor_calc
// Fractional baud divisor: clock*25 / (4 or 2 * rate), split by 100 into
// mantissa and a fraction rounded to sixteenths or eighths.
// ----------------------------------------------------------------------------
module usart_baud_divisor_calc (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ubd_pkg::APB_AW-1:0] paddr,
	input  logic [ubd_pkg::APB_DW-1:0] pwdata,
	output logic [ubd_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	ubd_req_if.sink                    req,
	ubd_rsp_if.source                  rsp
);

	logic [ubd_pkg::NUM_W-1:0] clk_x25;
	logic                      by_eight;
	ubd_pkg::cell_t            stage_d [ubd_pkg::NCELLS+1];
	logic                      stage_v [ubd_pkg::NCELLS+1];
	logic                      stage_r [ubd_pkg::NCELLS+1];

	ubd_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.clk_x25  (clk_x25),
		.by_eight (by_eight)
	);

	always_comb begin
		stage_d[0]      = '0;
		stage_d[0].num  = clk_x25;
		stage_d[0].den  = by_eight ? {1'b0, req.baud_rate, 1'b0} : {req.baud_rate, 2'b00};
		stage_d[0].zero = (req.baud_rate == '0);
	end
	assign stage_v[0] = req.valid;
	assign req.ready  = stage_r[0];

	for (genvar k = 0; k < ubd_pkg::NCELLS; k++) begin : g_cell
		ubd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_v[k]),
			.in_data   (stage_d[k]),
			.in_ready  (stage_r[k]),
			.out_valid (stage_v[k+1]),
			.out_data  (stage_d[k+1]),
			.out_ready (stage_r[k+1])
		);
	end

	ubd_post u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.by_eight    (by_eight),
		.in_valid    (stage_v[ubd_pkg::NCELLS]),
		.in_data     (stage_d[ubd_pkg::NCELLS]),
		.in_ready    (stage_r[ubd_pkg::NCELLS]),
		.out_valid   (rsp.valid),
		.out_divisor (rsp.divisor),
		.out_zero    (rsp.zero_rate_error),
		.out_ready   (rsp.ready)
	);

`ifndef SYNTHESIS
	a_zero_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.zero_rate_error) |-> (rsp.divisor == '0))
		else $error("zero rate item with nonzero divisor");
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid)
		else $error("request stalled with no result waiting");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_v[ubd_pkg::NCELLS] && stage_r[ubd_pkg::NCELLS]) |=> rsp.valid)
		else $error("item from last cell lost");
`endif

endmodule

[sim/usart_baud_divisor_calc_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usart_baud_divisor_calc_tb
// Checks the fractional baud divisor against a predictor of its arithmetic.
// Directed rates cover zero rate, the field extremes, fraction carry and
// mantissa truncation; random rates then run under many clock and
// oversampling settings with bursty input and a stalling output, including
// one long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module usart_baud_divisor_calc_tb;

	typedef logic [ubd_pkg::RATE_W-1:0] rate_t;
	typedef logic [ubd_pkg::CLK_W-1:0]  clk_t;
	typedef logic [ubd_pkg::APB_DW-1:0] apb_data_t;
	typedef logic [ubd_pkg::APB_AW-1:0] apb_addr_t;

	typedef struct packed {
		logic [ubd_pkg::DIV_W-1:0] divisor;
		logic                      zero_rate_error;
	} divisor_exp_t;

	localparam int LATENCY         = 35;
	localparam int IDLE_LIMIT      = 5000;
	localparam int RANDOM_PHASES   = 14;
	localparam int ITEMS_PER_PHASE = 70;
	localparam int HOLD_CYCLES     = 300;
	localparam int PRINT_CAP       = 100;

	localparam apb_addr_t ADDR_CLK      = {ubd_pkg::REG_CLK, 2'b00};
	localparam apb_addr_t ADDR_OVS      = {ubd_pkg::REG_OVS, 2'b00};
	localparam rate_t     RATE_MAX      = '1;
	localparam clk_t      CLK_MAX       = '1;
	localparam clk_t      CLK_RANGE_TOP = 28'd171798691;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      psel;
	logic      penable;
	logic      pwrite;
	apb_addr_t paddr;
	apb_data_t pwdata;
	apb_data_t prdata;
	logic      pready;

	ubd_req_if req_ch ();
	ubd_rsp_if rsp_ch ();

	usart_baud_divisor_calc dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// shadow of the block's registers
	clk_t cfg_clock_hz;
	logic cfg_by_eight;

	divisor_exp_t divisors_due[$];

	int unsigned rates_sent;
	int unsigned divisors_checked;
	int unsigned config_writes;
	int unsigned mismatch_count;
	int unsigned idle_cycles;

	// sender and receiver pacing
	bit          gaps_on;
	bit          stalls_on;
	int          burst_left;
	int          hold_left;
	logic [15:0] ready_pattern;
	logic [3:0]  stall_phase;

	int unsigned std_bauds[10] = '{300, 1200, 2400, 9600, 19200, 38400, 57600,
		115200, 460800, 4500000};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic divisor_exp_t predict_divisor(clk_t clk_hz, logic by_eight,
		rate_t rate);
		divisor_exp_t res;
		logic [63:0]  steps;
		logic [63:0]  scaled;
		logic [63:0]  mant;
		logic [63:0]  frac;
		logic [63:0]  packed_div;
		res.zero_rate_error = (rate == '0);
		res.divisor = '0;
		if (rate == '0)
			return res;
		steps = by_eight ? 64'(ubd_pkg::STEPS_8) : 64'(ubd_pkg::STEPS_16);
		scaled = (64'(clk_hz) * 64'(ubd_pkg::SCALE_25))
			/ (64'(rate) * (by_eight ? 64'd2 : 64'd4));
		mant = scaled / 64'(ubd_pkg::DEC_BASE);
		frac = ((scaled - mant * 64'(ubd_pkg::DEC_BASE)) * steps
			+ 64'(ubd_pkg::ROUND_HALF)) / 64'(ubd_pkg::DEC_BASE);
		// fraction rounded up to a whole step carries into the mantissa
		if (frac >= steps) begin
			frac = '0;
			mant = mant + 64'd1;
		end
		packed_div = (mant << 4) | frac;
		res.divisor = packed_div[ubd_pkg::DIV_W-1:0];
		return res;
	endfunction

	// first rate at or above 'first' whose fraction rounds up to a full step
	function automatic rate_t find_carry_rate(clk_t clk_hz, logic by_eight,
		int unsigned first);
		logic [63:0] steps;
		logic [63:0] scaled;
		steps = by_eight ? 64'(ubd_pkg::STEPS_8) : 64'(ubd_pkg::STEPS_16);
		for (int unsigned r = first; r < first + 200000; r++) begin
			scaled = (64'(clk_hz) * 64'(ubd_pkg::SCALE_25))
				/ (64'(r) * (by_eight ? 64'd2 : 64'd4));
			if ((scaled % 64'(ubd_pkg::DEC_BASE)) * steps + 64'(ubd_pkg::ROUND_HALF)
					>= 64'(ubd_pkg::DEC_BASE) * steps)
				return rate_t'(r);
		end
		return rate_t'(first);
	endfunction

	function automatic rate_t next_rate();
		int unsigned sel;
		logic [31:0] raw;
		sel = $urandom_range(0, 19);
		raw = $urandom();
		if (sel == 0)
			return '0;
		else if (sel <= 7)
			return raw[ubd_pkg::RATE_W-1:0];
		else if (sel <= 12)
			return rate_t'($urandom_range(1, 65535));
		else if (sel <= 16)
			return rate_t'(std_bauds[$urandom_range(0, 9)]);
		else if (sel <= 18)
			return rate_t'($urandom_range(1, 2000));
		else
			return RATE_MAX - rate_t'($urandom_range(0, 4095));
	endfunction

	function automatic clk_t next_clock();
		logic [31:0] raw;
		raw = $urandom();
		case ($urandom_range(0, 5))
			0: return clk_t'(8000000);
			1: return clk_t'(36000000);
			2: return clk_t'(72000000);
			3: return clk_t'($urandom_range(1000, 2000000));
			default: return raw[ubd_pkg::CLK_W-1:0];
		endcase
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	task automatic write_register(apb_addr_t addr, apb_data_t data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_CLK)
			cfg_clock_hz = data[ubd_pkg::CLK_W-1:0];
		else if (addr == ADDR_OVS)
			cfg_by_eight = data[0];
		config_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_register(apb_addr_t addr, apb_data_t want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch($sformatf("register 0x%0h read 0x%08h, want 0x%08h",
				addr, prdata, want));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_rate(rate_t rate);
		int gap;
		@(negedge clk);
		if (burst_left <= 0) begin
			gap = 0;
			if (gaps_on)
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 5);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.baud_rate <= rate;
		do @(posedge clk); while (!req_ch.ready);
		rates_sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (divisors_due.size() != 0)
			@(posedge clk);
	endtask

	// registers only change with the pipeline empty
	task automatic set_config(clk_t clk_hz, logic by_eight);
		apb_data_t noise;
		wait_drain();
		noise = $urandom();
		write_register(ADDR_CLK, {noise[ubd_pkg::APB_DW-1:ubd_pkg::CLK_W], clk_hz});
		write_register(ADDR_OVS, {noise[ubd_pkg::APB_DW-1:1], by_eight});
		check_register(ADDR_CLK, apb_data_t'(clk_hz));
		check_register(ADDR_OVS, apb_data_t'(by_eight));
	endtask

	task automatic test_register_reset();
		check_register(ADDR_CLK, apb_data_t'(ubd_pkg::CLK_RESET));
		check_register(ADDR_OVS, '0);
	endtask

	task automatic test_directed_rates();
		gaps_on = 0;
		stalls_on = 0;
		// reset setting, 8 MHz at 16x
		send_rate(26'd9600);
		send_rate(26'd115200);
		send_rate('0);
		send_rate(26'd1);
		send_rate(RATE_MAX);
		send_rate(find_carry_rate(ubd_pkg::CLK_RESET, 1'b0, 1000));
		// largest clock, 8x: mantissa truncation at low rates
		set_config(CLK_MAX, 1'b1);
		send_rate(26'd1);
		send_rate(RATE_MAX);
		send_rate(26'h2AAAAAA);
		send_rate(find_carry_rate(CLK_MAX, 1'b1, 1000));
		set_config('0, 1'b0);
		send_rate(26'd1);
		send_rate(26'd115200);
		set_config(CLK_RANGE_TOP, 1'b1);
		send_rate(26'd1);
		send_rate(26'd9600);
		send_rate('0);
		send_rate(26'h1555555);
		set_config(clk_t'(72000000), 1'b0);
		send_rate(26'd9600);
		send_rate(26'h2AAAAAA);
		send_rate(find_carry_rate(clk_t'(72000000), 1'b0, 2000));
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0)
				set_config(CLK_MAX, 1'b0);
			else if (phase == 1)
				set_config(CLK_RANGE_TOP, 1'b1);
			else
				set_config(next_clock(), $urandom_range(0, 1));
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			if (phase == 2) begin
				gaps_on = 0;
				stalls_on = 0;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_rate(next_rate());
		end
	endtask

	// output held off long enough for the whole pipeline to back up
	task automatic test_output_backpressure();
		wait_drain();
		gaps_on = 0;
		stalls_on = 1;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		for (int n = 0; n < 60; n++)
			send_rate(next_rate());
		wait_drain();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (!stalls_on) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			rsp_ch.ready <= ready_pattern[stall_phase];
			stall_phase <= stall_phase + 4'd1;
			if (stall_phase == 4'hF && $urandom_range(0, 3) == 0)
				ready_pattern <= 16'($urandom()) | 16'h0001;
		end
	end

	always @(posedge clk) begin : check_divisors
		divisor_exp_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				divisors_due.push_back(predict_divisor(cfg_clock_hz, cfg_by_eight,
					req_ch.baud_rate));
			if (rsp_ch.valid && rsp_ch.ready) begin
				divisors_checked++;
				if (divisors_due.size() == 0) begin
					report_mismatch($sformatf("divisor 0x%04h with no request pending",
						rsp_ch.divisor));
				end else begin
					want = divisors_due.pop_front();
					if (rsp_ch.divisor !== want.divisor)
						report_mismatch($sformatf("divisor 0x%04h, want 0x%04h",
							rsp_ch.divisor, want.divisor));
					if (rsp_ch.zero_rate_error !== want.zero_rate_error)
						report_mismatch($sformatf("zero_rate_error %b, want %b",
							rsp_ch.zero_rate_error, want.zero_rate_error));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.baud_rate = '0;
		rsp_ch.ready = 1'b1;
		cfg_clock_hz = ubd_pkg::CLK_RESET;
		cfg_by_eight = 1'b0;
		rates_sent = 0;
		divisors_checked = 0;
		config_writes = 0;
		mismatch_count = 0;
		idle_cycles = 0;
		gaps_on = 0;
		stalls_on = 0;
		burst_left = 0;
		hold_left = 0;
		ready_pattern = 16'($urandom()) | 16'h0001;
		stall_phase = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_reset();
		test_directed_rates();
		test_random_settings();
		test_output_backpressure();

		wait_drain();
		repeat (LATENCY + 5) @(posedge clk);
		if (divisors_due.size() != 0)
			report_mismatch($sformatf("%0d divisors never arrived", divisors_due.size()));

		$display("Sent %0d baud rates over %0d register writes in both oversampling modes;",
			rates_sent, config_writes);
		$display("%0d divisors checked, incl. zero rate, fraction carry and output stall.",
			divisors_checked);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[usart_baud_divisor_calc.f]
sv/ubd_pkg.sv
sv/ubd_req_if.sv
sv/ubd_rsp_if.sv
sv/ubd_apb.sv
sv/ubd_cell.sv
sv/ubd_post.sv
sv/usart_baud_divisor_calc.sv
sim/usart_baud_divisor_calc_tb.sv
